// ===== hw/rtl/mgva_pkg.sv =====
// shared types, constants and helper functions for the velocity advection block
package mgva_pkg;

  // grid geometry: 64 x 64 cells, two banks
  localparam int GRID_BITS = 6;
  localparam int ADDR_W    = 2 * GRID_BITS + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // field widths
  localparam int VEL_W = 32;
  localparam int CS_W  = 8;
  localparam int TS_W  = 31;

  // one half in Q16.16
  localparam logic signed [32:0] HALF_Q = 33'sd32768;

  // item operations
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ADVECT = 2'd1,
    OP_READ   = 2'd2,
    OP_SWAP   = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_WRITE,
    DP_SWAP,
    DP_RD_ADDR,
    DP_RD_OUT,
    DP_INIT_A,
    DP_INIT_B,
    DP_FIN_A,
    DP_FIN_B,
    DP_DIVX_GO,
    DP_DIVX_WAIT,
    DP_DIVY_GO,
    DP_DIVY_WAIT,
    DP_LOAD,
    DP_BLEND,
    DP_MID,
    DP_END,
    DP_WB
  } dp_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_SWAP,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_INIT,
    ST_FIN,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_LOAD,
    ST_BLEND,
    ST_MUL,
    ST_WB
  } ctrl_state_e;

  // command from controller to datapath
  typedef struct packed {
    dp_op_e     op;
    logic [2:0] step;
    logic       comp;
    logic       trace;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  item_op;
    logic div_done;
  } dp_stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if ((v[49:31] == '0) || (v[49:31] == '1)) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // base + product / 65536, rounded half up
  function automatic logic signed [31:0] blend_rnd(input logic signed [31:0] base,
                                                   input logic signed [49:0] prod);
    logic signed [49:0] s;
    s = {{2{base[31]}}, base, 16'b0} + prod + 50'sd32768;
    return s[47:16];
  endfunction

endpackage

// ===== hw/rtl/mgva_div.sv =====
// bit-serial floor divider of a signed position by the cell size
module mgva_div
  import mgva_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      dividend_i,
  input  logic [CS_W-1:0]         divisor_i,
  output logic signed [31:0]      quot_o,
  output logic                    done_o
);

  localparam int DVD_W = 31;

  logic             busy_q, done_q, neg_q;
  logic [4:0]       cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [CS_W-1:0]  rem_q;
  logic [CS_W:0]    trial, diff;
  logic             ge;
  logic [CS_W-1:0]  rem_d;

  // one quotient bit per cycle
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};
  assign rem_d = ge ? diff[CS_W-1:0] : trial[CS_W-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'(DVD_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DVD_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // magnitude and remainder; negative values divide their complement
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[31];
      dvd_q <= dividend_i[31] ? ~dividend_i[DVD_W-1:0] : dividend_i[DVD_W-1:0];
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quot_o = neg_q ? ~{1'b0, dvd_q} : {1'b0, dvd_q};
  assign done_o = done_q;

endmodule

// ===== hw/rtl/mgva_dp.sv =====
// datapath: config registers, field memories, divider, multiplier and sample logic
module mgva_dp
  import mgva_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic [1:0]              operation_i,
  input  logic [GRID_BITS-1:0]    cell_x_i,
  input  logic [GRID_BITS-1:0]    cell_y_i,
  input  logic signed [VEL_W-1:0] new_vel_x_i,
  input  logic signed [VEL_W-1:0] new_vel_y_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_index_i,
  input  logic [TS_W-1:0]         cfg_data_i,
  output logic signed [VEL_W-1:0] out_vel_x_o,
  output logic signed [VEL_W-1:0] out_vel_y_o,
  output logic                    done_o
);

  logic [CS_W-1:0]      cs_q;
  logic [TS_W-1:0]      ts_q;
  logic                 bank_q;
  op_e                  op_q;
  logic [GRID_BITS-1:0] cx_q, cy_q;
  logic signed [31:0]   wx_q, wy_q;
  logic signed [31:0]   org_x_q, org_y_q, pt_x_q, pt_y_q, gx_q, gy_q;
  logic signed [31:0]   ra_x_q, ra_y_q, rb_x_q, rb_y_q;
  logic signed [31:0]   v_q [2];
  logic signed [31:0]   c_q [4];
  logic signed [31:0]   lo_q, hi_q, qv_q;
  logic signed [65:0]   prod_q;
  logic [31:0]          rdx_q, rdy_q;
  logic                 inb_q;
  logic signed [31:0]   out_x_q, out_y_q;
  logic                 done_q;

  logic [31:0] mem_x [MEM_DEPTH];
  logic [31:0] mem_y [MEM_DEPTH];

  // configuration, bank select and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= CS_W'(1);
      ts_q   <= TS_W'(655);
      bank_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CELL_SIZE: cs_q <= cfg_data_i[CS_W-1:0];
          CFG_TIME_STEP: ts_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.op == DP_SWAP) begin
        bank_q <= ~bank_q;
      end
      done_q <= (cmd_i.op == DP_RD_OUT) || (cmd_i.op == DP_WB);
    end
  end

  // derived constants of the step
  logic [CS_W-1:0]    cs_eff;
  logic signed [31:0] nt, ht;
  logic [13:0]        cxcs, cycs;
  logic [31:0]        bx, by, halfp;

  assign cs_eff = (cs_q == '0) ? CS_W'(1) : cs_q;
  assign nt     = 32'sd0 - $signed({1'b0, ts_q});
  assign ht     = (nt + 32'sd1) >>> 1;
  assign cxcs   = 14'(cx_q * cs_eff);
  assign cycs   = 14'(cy_q * cs_eff);
  assign bx     = {2'b0, cxcs, 16'b0};
  assign by     = {2'b0, cycs, 16'b0};
  assign halfp  = {9'b0, cs_eff, 15'b0};

  // sample coordinates, neighbor index and bounds
  logic signed [32:0] sx, sy;
  logic signed [16:0] si, sj;
  logic [15:0]        fx, fy;
  logic [1:0]         kk;
  logic signed [17:0] ii, jj;
  logic               in_grid;
  logic [ADDR_W-1:0]  samp_addr, raddr, waddr;
  logic               we;
  logic [31:0]        wdx, wdy;

  assign sx = cmd_i.comp ? ({gx_q[31], gx_q} - HALF_Q) : {gx_q[31], gx_q};
  assign sy = cmd_i.comp ? {gy_q[31], gy_q} : ({gy_q[31], gy_q} - HALF_Q);
  assign si = sx[32:16];
  assign sj = sy[32:16];
  assign fx = sx[15:0];
  assign fy = sy[15:0];
  assign kk = cmd_i.step[1:0];
  assign ii = {si[16], si} + {17'b0, kk[0]};
  assign jj = {sj[16], sj} + {17'b0, kk[1]};
  assign in_grid = (ii[17:GRID_BITS] == '0) && (jj[17:GRID_BITS] == '0);
  assign samp_addr = {bank_q, jj[GRID_BITS-1:0], ii[GRID_BITS-1:0]};

  // memory port selection
  always_comb begin
    raddr = (cmd_i.op == DP_RD_ADDR) ? {bank_q, cy_q, cx_q} : samp_addr;
    we    = 1'b0;
    waddr = {bank_q, cy_q, cx_q};
    wdx   = wx_q;
    wdy   = wy_q;
    if (cmd_i.op == DP_WRITE) begin
      we = 1'b1;
    end else if (cmd_i.op == DP_WB) begin
      we    = 1'b1;
      waddr = {~bank_q, cy_q, cx_q};
      wdx   = v_q[0];
      wdy   = v_q[1];
    end
  end

  // field memories, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[waddr] <= wdx;
      mem_y[waddr] <= wdy;
    end
    rdx_q <= mem_x[raddr];
    rdy_q <= mem_y[raddr];
    inb_q <= in_grid;
  end

  // divider, shared by both axes
  logic               div_start, div_done;
  logic signed [31:0] div_quot;

  assign div_start = (cmd_i.op == DP_DIVX_GO) || (cmd_i.op == DP_DIVY_GO);

  mgva_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((cmd_i.op == DP_DIVY_GO) ? pt_y_q : pt_x_q),
    .divisor_i  (cs_eff),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] kq;

  assign kq = (cmd_i.op == DP_MID) ? ht : nt;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == DP_BLEND) begin
      unique case (cmd_i.step)
        3'd0: begin
          mul_a = {c_q[1][31], c_q[1]} - {c_q[0][31], c_q[0]};
          mul_b = {17'b0, fx};
        end
        3'd2: begin
          mul_a = {c_q[3][31], c_q[3]} - {c_q[2][31], c_q[2]};
          mul_b = {17'b0, fx};
        end
        3'd4: begin
          mul_a = {hi_q[31], hi_q} - {lo_q[31], lo_q};
          mul_b = {17'b0, fy};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if ((cmd_i.op == DP_MID) || (cmd_i.op == DP_END)) begin
      mul_a = {kq[31], kq};
      mul_b = (cmd_i.step == 3'd2) ? {v_q[1][31], v_q[1]} : {v_q[0][31], v_q[0]};
    end
  end

  // rounded product and position update
  logic signed [65:0] prod_r;
  logic signed [31:0] qv_d, newx, newy;

  assign prod_r = prod_q + 66'sd32768;
  assign qv_d   = sat32(prod_r[65:16]);
  assign newx   = sat32({{18{org_x_q[31]}}, org_x_q} + {{18{qv_q[31]}}, qv_q});
  assign newy   = sat32({{18{org_y_q[31]}}, org_y_q} + {{18{qv_q[31]}}, qv_q});

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    qv_q   <= qv_d;
    unique case (cmd_i.op)
      DP_LATCH: begin
        op_q <= op_e'(operation_i);
        cx_q <= cell_x_i;
        cy_q <= cell_y_i;
        wx_q <= new_vel_x_i;
        wy_q <= new_vel_y_i;
      end
      DP_INIT_A: begin
        org_x_q <= bx;
        org_y_q <= by + halfp;
        pt_x_q  <= bx;
        pt_y_q  <= by + halfp;
      end
      DP_INIT_B: begin
        org_x_q <= bx + halfp;
        org_y_q <= by;
        pt_x_q  <= bx + halfp;
        pt_y_q  <= by;
      end
      DP_FIN_A: begin
        pt_x_q <= ra_x_q;
        pt_y_q <= ra_y_q;
      end
      DP_FIN_B: begin
        pt_x_q <= rb_x_q;
        pt_y_q <= rb_y_q;
      end
      DP_DIVX_WAIT: if (div_done) gx_q <= div_quot;
      DP_DIVY_WAIT: if (div_done) gy_q <= div_quot;
      DP_LOAD: begin
        if (cmd_i.step != 3'd0) begin
          c_q[2'(cmd_i.step - 3'd1)] <= inb_q ? (cmd_i.comp ? rdy_q : rdx_q) : 32'sd0;
        end
      end
      DP_BLEND: begin
        if (cmd_i.step == 3'd1) lo_q <= blend_rnd(c_q[0], prod_q[49:0]);
        if (cmd_i.step == 3'd3) hi_q <= blend_rnd(c_q[2], prod_q[49:0]);
        if (cmd_i.step == 3'd5) v_q[cmd_i.comp] <= blend_rnd(lo_q, prod_q[49:0]);
      end
      DP_MID: begin
        if (cmd_i.step == 3'd2) pt_x_q <= newx;
        if (cmd_i.step == 3'd4) pt_y_q <= newy;
      end
      DP_END: begin
        if (cmd_i.step == 3'd2) begin
          if (cmd_i.trace) rb_x_q <= newx;
          else ra_x_q <= newx;
        end
        if (cmd_i.step == 3'd4) begin
          if (cmd_i.trace) rb_y_q <= newy;
          else ra_y_q <= newy;
        end
      end
      DP_RD_OUT: begin
        out_x_q <= rdx_q;
        out_y_q <= rdy_q;
      end
      DP_WB: begin
        out_x_q <= v_q[0];
        out_y_q <= v_q[1];
      end
      default: ;
    endcase
  end

  assign stat_o.item_op  = op_q;
  assign stat_o.div_done = div_done;
  assign out_vel_x_o     = out_x_q;
  assign out_vel_y_o     = out_y_q;
  assign done_o          = done_q;

  // result strobe follows a read-out or write-back command
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.op == DP_RD_OUT || cmd_i.op == DP_WB))
    else $error("result strobe without read-out or write-back");

  // bank select only moves on a swap command
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != DP_SWAP) |=> $stable(bank_q))
    else $error("bank select changed without swap");

endmodule

// ===== hw/rtl/mgva_ctrl.sv =====
// controller state machine sequencing the advect, read, write and swap items
module mgva_ctrl
  import mgva_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  localparam logic [1:0] PASS_ORIGIN = 2'd0;
  localparam logic [1:0] PASS_MID    = 2'd1;
  localparam logic [1:0] PASS_FINAL  = 2'd2;

  ctrl_state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [1:0]  pass_q, pass_d;
  logic        trace_q, trace_d;
  logic        comp_q, comp_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= PASS_ORIGIN;
      trace_q <= 1'b0;
      comp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
      trace_q <= trace_d;
      comp_q  <= comp_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    trace_d = trace_q;
    comp_d  = comp_q;
    cmd_o.op    = DP_NOP;
    cmd_o.step  = step_q;
    cmd_o.comp  = comp_q;
    cmd_o.trace = trace_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = DP_LATCH;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.item_op)
          OP_WRITE:  state_d = ST_WRITE;
          OP_SWAP:   state_d = ST_SWAP;
          OP_READ:   state_d = ST_RD_ADDR;
          OP_ADVECT: begin
            trace_d = 1'b0;
            pass_d  = PASS_ORIGIN;
            state_d = ST_INIT;
          end
        endcase
      end
      ST_WRITE: begin
        cmd_o.op = DP_WRITE;
        state_d  = ST_IDLE;
      end
      ST_SWAP: begin
        cmd_o.op = DP_SWAP;
        state_d  = ST_IDLE;
      end
      ST_RD_ADDR: begin
        cmd_o.op = DP_RD_ADDR;
        state_d  = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.op = DP_RD_OUT;
        state_d  = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.op = trace_q ? DP_INIT_B : DP_INIT_A;
        state_d  = ST_DIVX_GO;
      end
      ST_FIN: begin
        cmd_o.op = trace_q ? DP_FIN_B : DP_FIN_A;
        state_d  = ST_DIVX_GO;
      end
      ST_DIVX_GO: begin
        cmd_o.op = DP_DIVX_GO;
        state_d  = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        cmd_o.op = DP_DIVX_WAIT;
        if (stat_i.div_done) state_d = ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        cmd_o.op = DP_DIVY_GO;
        state_d  = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        cmd_o.op = DP_DIVY_WAIT;
        if (stat_i.div_done) begin
          // final pass samples only the component its trace feeds
          comp_d  = (pass_q == PASS_FINAL) && trace_q;
          step_d  = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.op = DP_LOAD;
        if (step_q == 3'd4) begin
          step_d  = '0;
          state_d = ST_BLEND;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_BLEND: begin
        cmd_o.op = DP_BLEND;
        if (step_q == 3'd5) begin
          step_d = '0;
          if (!comp_q && (pass_q != PASS_FINAL)) begin
            comp_d  = 1'b1;
            state_d = ST_LOAD;
          end else if (pass_q != PASS_FINAL) begin
            state_d = ST_MUL;
          end else if (!trace_q) begin
            trace_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_WB;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_MUL: begin
        cmd_o.op = (pass_q == PASS_ORIGIN) ? DP_MID : DP_END;
        if (step_q == 3'd4) begin
          step_d = '0;
          if (pass_q == PASS_ORIGIN) begin
            pass_d  = PASS_MID;
            state_d = ST_DIVX_GO;
          end else if (!trace_q) begin
            trace_d = 1'b1;
            pass_d  = PASS_ORIGIN;
            state_d = ST_INIT;
          end else begin
            trace_d = 1'b0;
            pass_d  = PASS_FINAL;
            state_d = ST_FIN;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_WB: begin
        cmd_o.op = DP_WB;
        state_d  = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // an accepted word is decoded next
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_DECODE))
    else $error("accepted word not decoded");

  // load and blend counters stay in range
  a_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (step_q <= 3'd4))
    else $error("load step out of range");

  a_blend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND || state_q == ST_MUL) |-> (step_q <= 3'd5))
    else $error("blend step out of range");

  // write-back returns to idle
  a_wb_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |=> (state_q == ST_IDLE))
    else $error("write-back did not finish");

endmodule

// ===== hw/rtl/mac_grid_velocity_advection.sv =====
// top level: semi-Lagrangian RK2 velocity advection on a two-bank staggered grid
// An item is taken when start is high and busy is low; busy stays high until the
// item is finished, and one item is worked at a time. An advect evaluates the
// velocity field at six points, each needing two floor divisions by the cell size
// on a bit-serial divider, plus four-read, three-blend samples on the single read
// port of each field memory and one shared multiplier. Results appear on
// out_vel_x_o/out_vel_y_o for exactly one cycle with done_o high; the receiver
// cannot hold them off. Configuration is always ready and must be written while idle.
module mac_grid_velocity_advection
  import mgva_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation_i,
  input  logic [GRID_BITS-1:0]    cell_x_i,
  input  logic [GRID_BITS-1:0]    cell_y_i,
  input  logic signed [VEL_W-1:0] new_vel_x_i,
  input  logic signed [VEL_W-1:0] new_vel_y_i,
  output logic signed [VEL_W-1:0] out_vel_x_o,
  output logic signed [VEL_W-1:0] out_vel_y_o,
  output logic                    done_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [TS_W-1:0]         cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  mgva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // datapath
  mgva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .new_vel_x_i (new_vel_x_i),
    .new_vel_y_i (new_vel_y_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_vel_x_o (out_vel_x_o),
    .out_vel_y_o (out_vel_y_o),
    .done_o      (done_o)
  );

endmodule

// ===== dv/mgva_checker.sv =====
// checker for the velocity advection block: predicts every result word and compares
`timescale 1ns / 1ps

module mgva_checker
  import mgva_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              operation_i,
  input  logic [GRID_BITS-1:0]    cell_x_i,
  input  logic [GRID_BITS-1:0]    cell_y_i,
  input  logic signed [VEL_W-1:0] new_vel_x_i,
  input  logic signed [VEL_W-1:0] new_vel_y_i,
  input  logic signed [VEL_W-1:0] out_vel_x_o,
  input  logic signed [VEL_W-1:0] out_vel_y_o,
  input  logic                    done_o,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [TS_W-1:0]         cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int  NCELLS = 1 << (2 * GRID_BITS);
  localparam int  GRID_N = 1 << GRID_BITS;
  localparam longint ONE_Q = 65536;
  localparam longint HLF_Q = 32768;

  typedef struct {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } vel_pair_t;

  // model state: both banks of both face fields, bank pointer, registers
  logic signed [VEL_W-1:0] vel_x_mem [2*NCELLS];
  logic signed [VEL_W-1:0] vel_y_mem [2*NCELLS];
  logic                    cur_bank;
  logic [CS_W-1:0]         cs_reg;
  logic [TS_W-1:0]         ts_reg;
  vel_pair_t               vel_q [$];
  int                      fails;

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_q16(longint p);
    return p >>> 16;
  endfunction

  function automatic longint floor_div_cs(longint p, longint d);
    if (p >= 0) return p / d;
    return -((-(p + 1)) / d) - 1;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return sat_q(floor_q16(a * b + HLF_Q));
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint f);
    return floor_q16(a * (ONE_Q - f) + b * f + HLF_Q);
  endfunction

  function automatic longint cs_eff();
    return (cs_reg == 0) ? 64'sd1 : longint'(cs_reg);
  endfunction

  // cells off the grid read as zero
  function automatic longint grid_val(bit comp, longint i, longint j);
    int addr;
    if (i < 0 || i >= GRID_N || j < 0 || j >= GRID_N) return 0;
    addr = int'(cur_bank) * NCELLS + int'(j) * GRID_N + int'(i);
    return comp ? longint'(vel_y_mem[addr]) : longint'(vel_x_mem[addr]);
  endfunction

  // bilinear sample at grid point, Q16.16
  function automatic longint interp(bit comp, longint gx, longint gy);
    longint i, j, fx, fy, lo, hi;
    i  = floor_q16(gx);
    j  = floor_q16(gy);
    fx = gx - i * ONE_Q;
    fy = gy - j * ONE_Q;
    lo = lerp_q(grid_val(comp, i, j), grid_val(comp, i + 1, j), fx);
    hi = lerp_q(grid_val(comp, i, j + 1), grid_val(comp, i + 1, j + 1), fx);
    return lerp_q(lo, hi, fy);
  endfunction

  // velocity component at a world position, faces offset by half a cell
  function automatic longint face_vel(bit comp, longint px, longint py);
    longint gx, gy;
    gx = floor_div_cs(px, cs_eff());
    gy = floor_div_cs(py, cs_eff());
    if (!comp) return interp(1'b0, gx, gy - HLF_Q);
    return interp(1'b1, gx - HLF_Q, gy);
  endfunction

  // midpoint backtrace over minus the timestep
  function automatic void backtrace(longint px, longint py, longint nt,
                                    output longint rx, output longint ry);
    longint ht, vx, vy, mx, my;
    ht = mul_q(nt, HLF_Q);
    vx = face_vel(1'b0, px, py);
    vy = face_vel(1'b1, px, py);
    mx = sat_q(px + mul_q(ht, vx));
    my = sat_q(py + mul_q(ht, vy));
    vx = face_vel(1'b0, mx, my);
    vy = face_vel(1'b1, mx, my);
    rx = sat_q(px + mul_q(nt, vx));
    ry = sat_q(py + mul_q(nt, vy));
  endfunction

  function automatic vel_pair_t advect_cell(longint cx, longint cy);
    vel_pair_t r;
    longint cs, nt, bx, by, hc, px, py, qx, qy;
    cs = cs_eff();
    nt = -longint'(ts_reg);
    bx = sat_q(cx * cs * ONE_Q);
    by = sat_q(cy * cs * ONE_Q);
    hc = cs * HLF_Q;
    backtrace(bx, sat_q(by + hc), nt, px, py);
    backtrace(sat_q(bx + hc), by, nt, qx, qy);
    r.vx = face_vel(1'b0, px, py);
    r.vy = face_vel(1'b1, qx, qy);
    return r;
  endfunction

  // watch all channels: results first, then the accepted word, then registers
  always @(posedge clk_i or negedge rst_ni) begin
    vel_pair_t exp_w;
    int cur_a, oth_a;
    if (!rst_ni) begin
      cur_bank = 1'b0;
      cs_reg   = 8'd1;
      ts_reg   = 31'd655;
      vel_q.delete();
      fails    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_o) begin
        if (vel_q.size() == 0) begin
          $error("result word with nothing expected: x=%0d y=%0d", out_vel_x_o, out_vel_y_o);
          fails++;
        end else begin
          exp_w = vel_q.pop_front();
          if (out_vel_x_o !== exp_w.vx) begin
            $error("out_vel_x: expected %0d, got %0d", exp_w.vx, out_vel_x_o);
            fails++;
          end
          if (out_vel_y_o !== exp_w.vy) begin
            $error("out_vel_y: expected %0d, got %0d", exp_w.vy, out_vel_y_o);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        cur_a = int'(cur_bank) * NCELLS + int'(cell_y_i) * GRID_N + int'(cell_x_i);
        oth_a = int'(!cur_bank) * NCELLS + int'(cell_y_i) * GRID_N + int'(cell_x_i);
        case (op_e'(operation_i))
          OP_WRITE: begin
            vel_x_mem[cur_a] = new_vel_x_i;
            vel_y_mem[cur_a] = new_vel_y_i;
          end
          OP_SWAP: begin
            cur_bank = !cur_bank;
          end
          OP_READ: begin
            exp_w.vx = vel_x_mem[cur_a];
            exp_w.vy = vel_y_mem[cur_a];
            vel_q.push_back(exp_w);
          end
          default: begin
            exp_w = advect_cell(longint'(cell_x_i), longint'(cell_y_i));
            vel_x_mem[oth_a] = exp_w.vx;
            vel_y_mem[oth_a] = exp_w.vy;
            vel_q.push_back(exp_w);
          end
        endcase
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CELL_SIZE) cs_reg = cfg_data_i[CS_W-1:0];
        else ts_reg = cfg_data_i;
      end
      fail_count_o <= fails;
      pending_o    <= vel_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench top for the velocity advection block: stimulus, configuration and verdict
`timescale 1ns / 1ps

module tb;
  import mgva_pkg::*;

  localparam int NPHASE   = 7;
  localparam int PHASE_N  = 275;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              operation_i = OP_WRITE;
  logic [GRID_BITS-1:0]    cell_x_i = '0;
  logic [GRID_BITS-1:0]    cell_y_i = '0;
  logic signed [VEL_W-1:0] new_vel_x_i = '0;
  logic signed [VEL_W-1:0] new_vel_y_i = '0;
  logic signed [VEL_W-1:0] out_vel_x_o;
  logic signed [VEL_W-1:0] out_vel_y_o;
  logic                    done_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_index_i = CFG_CELL_SIZE;
  logic [TS_W-1:0]         cfg_data_i = '0;
  int                      fail_count;
  int                      pending;
  bit                      gaps_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mac_grid_velocity_advection uut (.*);
  mgva_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // run limit, far beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // random Q16.16 velocity, biased toward magnitudes that move a few cells
  function automatic logic [31:0] rand_vel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 524288) - 262144;
    if (sel < 6) return $urandom_range(0, 8388608) - 4194304;
    if (sel == 6) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (sel == 7) return '0;
    return $urandom();
  endfunction

  function automatic logic [5:0] rand_cell();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return 6'($urandom_range(0, 63));
  endfunction

  // send one command word, returns at the edge that takes it
  task automatic send_word(op_e op, logic [5:0] x, logic [5:0] y,
                           logic [31:0] vx, logic [31:0] vy);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    cell_x_i    <= x;
    cell_y_i    <= y;
    new_vel_x_i <= vx;
    new_vel_y_i <= vy;
    do @(posedge clk_i); while (busy);
  endtask

  // drain: every result in and the block quiet, then a further idle wait
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // valid stays high; the caller drops it after the last register word
  task automatic write_reg(logic idx, logic [TS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  initial begin
    logic [CS_W-1:0] cs_tab [NPHASE];
    logic [TS_W-1:0] ts_tab [NPHASE];
    int sel;
    int wait_n;

    cs_tab = '{8'd1, 8'd0, 8'd255, 8'd4, 8'd1, 8'd16, 8'd1};
    ts_tab = '{31'd655, 31'd65536, 31'h7FFF_FFFF, 31'd0, 31'd32768, 31'd6553600, 31'd1};
    cs_tab[4] = CS_W'($urandom_range(1, 255));
    ts_tab[4] = TS_W'($urandom() >> 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill both banks so no advect ever touches an unwritten cell
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < 4096; c++) begin
        send_word(OP_WRITE, c[5:0], c[11:6], rand_vel(), rand_vel());
      end
      send_word(OP_SWAP, '0, '0, '0, '0);
    end

    // directed: extremes at the corners, reads, advects and a swap pair
    send_word(OP_WRITE, 6'd0, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 6'd63, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_WRITE, 6'd63, 6'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_WRITE, 6'd0, 6'd63, 32'h0001_0000, 32'hFFFF_0000);
    send_word(OP_READ, 6'd0, 6'd0, '0, '0);
    send_word(OP_READ, 6'd63, 6'd63, '0, '0);
    send_word(OP_READ, 6'd63, 6'd0, '0, '0);
    send_word(OP_READ, 6'd0, 6'd63, '0, '0);
    send_word(OP_ADVECT, 6'd0, 6'd0, '0, '0);
    send_word(OP_ADVECT, 6'd63, 6'd63, '0, '0);
    send_word(OP_ADVECT, 6'd63, 6'd0, '0, '0);
    send_word(OP_ADVECT, 6'd0, 6'd63, '0, '0);
    send_word(OP_ADVECT, 6'd31, 6'd32, '0, '0);
    send_word(OP_SWAP, '0, '0, '0, '0);
    send_word(OP_READ, 6'd0, 6'd0, '0, '0);
    send_word(OP_READ, 6'd63, 6'd63, '0, '0);
    send_word(OP_ADVECT, 6'd0, 6'd0, '0, '0);
    send_word(OP_SWAP, '0, '0, '0, '0);
    send_word(OP_READ, 6'd31, 6'd32, '0, '0);

    // random phases, each under its own register setting
    for (int p = 0; p < NPHASE; p++) begin
      settle();
      if ($urandom_range(0, 3) == 0) begin
        wait_n = $urandom_range(1, 3);
        repeat (wait_n) @(posedge clk_i);
      end
      write_reg(CFG_CELL_SIZE, {23'd0, cs_tab[p]});
      write_reg(CFG_TIME_STEP, ts_tab[p]);
      cfg_valid_i <= 1'b0;
      gaps_on = (p != NPHASE - 1);
      for (int k = 0; k < PHASE_N; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 6) send_word(OP_WRITE, rand_cell(), rand_cell(), rand_vel(), rand_vel());
        else if (sel < 13) send_word(OP_ADVECT, rand_cell(), rand_cell(), '0, '0);
        else if (sel < 18) send_word(OP_READ, rand_cell(), rand_cell(), rand_vel(), rand_vel());
        else send_word(OP_SWAP, rand_cell(), rand_cell(), rand_vel(), rand_vel());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mgva_pkg.sv
hw/rtl/mgva_div.sv
hw/rtl/mgva_dp.sv
hw/rtl/mgva_ctrl.sv
hw/rtl/mac_grid_velocity_advection.sv
dv/mgva_checker.sv
dv/tb.sv
